// File: rtl/bmcd_pkg.sv
// shared constants, codes and types of the button multi-click detector
`default_nettype none

package bmcd_pkg;

	localparam int NUM_BUTTONS_DEF = 8;
	localparam int TICK_WIDTH_DEF  = 16;

	localparam int REQ_W   = 2;
	localparam int ID_W    = 3;
	localparam int EV_W    = 2;
	localparam int CNT_W   = 8;
	localparam int CFG_W   = 16;
	localparam int CFG_IDX_W = 2;

	localparam int S_TDATA_W = 8;
	localparam int S_TUSER_W = 2;
	localparam int M_TDATA_W = 24;

	// request kinds
	localparam logic [REQ_W-1:0] REQ_SCAN  = 2'd0;
	localparam logic [REQ_W-1:0] REQ_READ  = 2'd1;
	localparam logic [REQ_W-1:0] REQ_CLEAR = 2'd2;

	// slot events
	localparam logic [EV_W-1:0] EV_IDLE      = 2'd0;
	localparam logic [EV_W-1:0] EV_PRESSED   = 2'd1;
	localparam logic [EV_W-1:0] EV_REPRESSED = 2'd2;
	localparam logic [EV_W-1:0] EV_LONG      = 2'd3;

	localparam logic [CNT_W-1:0] LONG_REPORT = 8'hFF;
	localparam logic [CNT_W-1:0] CLICK_MAX   = 8'd254;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] REG_DEBOUNCE     = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_CLICK_WINDOW = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_REPRESS      = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_LONG_PRESS   = 2'd3;

	localparam logic [CFG_W-1:0] DEBOUNCE_RST     = 16'd5;
	localparam logic [CFG_W-1:0] CLICK_WINDOW_RST = 16'd25;
	localparam logic [CFG_W-1:0] REPRESS_RST      = 16'd15;
	localparam logic [CFG_W-1:0] LONG_PRESS_RST   = 16'd100;

	typedef struct packed {
		logic [CFG_W-1:0] long_press;
		logic [CFG_W-1:0] repress_window;
		logic [CFG_W-1:0] click_window;
		logic [CFG_W-1:0] debounce;
	} cfg_t;

endpackage

`default_nettype wire

// File: rtl/bmcd_cfg_regs.sv
// timing configuration registers of the button multi-click detector
`default_nettype none

module bmcd_cfg_regs (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          cfg_valid,
	output logic                               cfg_ready,
	input  wire logic [bmcd_pkg::CFG_IDX_W-1:0] cfg_index,
	input  wire logic [bmcd_pkg::CFG_W-1:0]    cfg_data,
	output bmcd_pkg::cfg_t                     cfg
);

	bmcd_pkg::cfg_t cfg_q;

	assign cfg_ready = 1'b1;
	assign cfg       = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.debounce       <= bmcd_pkg::DEBOUNCE_RST;
			cfg_q.click_window   <= bmcd_pkg::CLICK_WINDOW_RST;
			cfg_q.repress_window <= bmcd_pkg::REPRESS_RST;
			cfg_q.long_press     <= bmcd_pkg::LONG_PRESS_RST;
		end else if (cfg_valid) begin
			case (cfg_index)
				bmcd_pkg::REG_DEBOUNCE:     cfg_q.debounce       <= cfg_data;
				bmcd_pkg::REG_CLICK_WINDOW: cfg_q.click_window   <= cfg_data;
				bmcd_pkg::REG_REPRESS:      cfg_q.repress_window <= cfg_data;
				bmcd_pkg::REG_LONG_PRESS:   cfg_q.long_press     <= cfg_data;
				default: begin
				end
			endcase
		end
	end

endmodule

`default_nettype wire

// File: rtl/bmcd_slot_mem.sv
// per-button slot memory, one write and one registered read per cycle
`default_nettype none

module bmcd_slot_mem #(
	parameter int DEPTH  = bmcd_pkg::NUM_BUTTONS_DEF,
	parameter int DATA_W = 50,
	parameter int AW     = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              rd_en,
	input  wire logic [AW-1:0]     rd_addr,
	output logic [DATA_W-1:0]      rd_data,
	output logic                   rd_valid,
	input  wire logic              wr_en,
	input  wire logic [AW-1:0]     wr_addr,
	input  wire logic [DATA_W-1:0] wr_data
);

	logic [DATA_W-1:0] mem [DEPTH];
	logic [DEPTH-1:0]  written_q;
	logic [DATA_W-1:0] rd_data_q;
	logic              rd_valid_q;

	assign rd_data  = rd_data_q;
	assign rd_valid = rd_valid_q;

	// read returns the old entry when the same entry is written at that edge
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	// an entry never written since reset reads with rd_valid low
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			written_q  <= '0;
			rd_valid_q <= 1'b0;
		end else begin
			if (rd_en) begin
				rd_valid_q <= written_q[rd_addr];
			end
			if (wr_en) begin
				written_q[wr_addr] <= 1'b1;
			end
		end
	end

endmodule

`default_nettype wire

// File: rtl/button_multi_click_detector.sv
// top level of the button multi-click and long-press detector
// Takes one transaction per clock cycle while the output is not stalled, scans of
// different buttons and of the same button back to back alike. A transaction
// reads its button's slot from the slot memory in the cycle it is accepted, the
// slot is updated and written back as the transaction leaves stage 1, and the
// result is held in an output register; the registered memory read is bridged
// by forwarding the slot being written. Every slot reads as idle with zero
// counts straight after reset, without a clearing pass. Configuration is to be
// written only while the block is idle; the block itself does not enforce this.
`default_nettype none

module button_multi_click_detector #(
	parameter int NUM_BUTTONS = bmcd_pkg::NUM_BUTTONS_DEF,
	parameter int TICK_WIDTH  = bmcd_pkg::TICK_WIDTH_DEF
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           s_tvalid,
	output logic                                s_tready,
	// button_id [2:0], pressed [3], zero [7:4]
	input  wire logic [bmcd_pkg::S_TDATA_W-1:0] s_tdata,
	// req_type [1:0]
	input  wire logic [bmcd_pkg::S_TUSER_W-1:0] s_tuser,
	output logic                                m_tvalid,
	input  wire logic                           m_tready,
	// event_res [1:0], report_valid [2], report_count [10:3],
	// captured_count [18:11], zero [23:19]
	output logic [bmcd_pkg::M_TDATA_W-1:0]      m_tdata,
	input  wire logic                           cfg_valid,
	output logic                                cfg_ready,
	input  wire logic [bmcd_pkg::CFG_IDX_W-1:0] cfg_index,
	input  wire logic [bmcd_pkg::CFG_W-1:0]     cfg_data
);

	localparam int AW = (NUM_BUTTONS > 1) ? $clog2(NUM_BUTTONS) : 1;
	localparam int IW = (AW > bmcd_pkg::ID_W) ? AW : bmcd_pkg::ID_W;
	localparam int CW = (TICK_WIDTH > bmcd_pkg::CFG_W) ? TICK_WIDTH : bmcd_pkg::CFG_W;
	localparam int RES_W = bmcd_pkg::EV_W + 1 + 2 * bmcd_pkg::CNT_W;

	typedef struct packed {
		logic [TICK_WIDTH-1:0]        release_ticks;
		logic [TICK_WIDTH-1:0]        press_ticks;
		logic [bmcd_pkg::CNT_W-1:0]   captured;
		logic [bmcd_pkg::CNT_W-1:0]   clicks;
		logic [bmcd_pkg::EV_W-1:0]    event_state;
	} slot_t;

	localparam int SLOT_W = $bits(slot_t);

	bmcd_pkg::cfg_t cfg;

	// input side
	logic                         in_accept;
	logic [bmcd_pkg::REQ_W-1:0]   in_req;
	logic [bmcd_pkg::ID_W-1:0]    in_id;
	logic [IW-1:0]                in_id_ext;
	logic [AW-1:0]                in_addr;
	logic                         in_range;

	// stage 1
	logic                         vld_s1;
	logic [bmcd_pkg::REQ_W-1:0]   req_s1;
	logic [AW-1:0]                addr_s1;
	logic                         lvl_s1;
	logic                         inr_s1;
	logic                         hit_s1;
	slot_t                        fwd_s1;
	logic                         adv_s1;

	// memory
	logic [SLOT_W-1:0]            rd_data;
	logic                         rd_valid;
	logic                         wr_en;
	slot_t                        cur;
	slot_t                        nxt;

	// step results
	logic                         rep_valid;
	logic [bmcd_pkg::CNT_W-1:0]   rep_count;
	logic [bmcd_pkg::CNT_W-1:0]   cap_out;
	logic [TICK_WIDTH-1:0]        press_inc;
	logic [TICK_WIDTH-1:0]        rel_inc;
	logic [RES_W-1:0]             res;

	// output register
	logic                         out_valid_q;
	logic [RES_W-1:0]             out_data_q;

	assign in_req    = s_tuser;
	assign in_id     = s_tdata[bmcd_pkg::ID_W-1:0];
	assign in_id_ext = IW'(in_id);
	assign in_addr   = in_id_ext[AW-1:0];
	assign in_range  = (9'(in_id) < 9'(NUM_BUTTONS));

	assign adv_s1    = !out_valid_q || m_tready;
	assign s_tready  = !vld_s1 || adv_s1;
	assign in_accept = s_tvalid && s_tready;
	assign wr_en     = vld_s1 && adv_s1 && inr_s1;

	bmcd_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	bmcd_slot_mem #(
		.DEPTH  (NUM_BUTTONS),
		.DATA_W (SLOT_W),
		.AW     (AW)
	) u_mem (
		.clk      (clk),
		.arst_n   (arst_n),
		.rd_en    (in_accept),
		.rd_addr  (in_addr),
		.rd_data  (rd_data),
		.rd_valid (rd_valid),
		.wr_en    (wr_en),
		.wr_addr  (addr_s1),
		.wr_data  (nxt)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (in_accept) begin
				vld_s1 <= 1'b1;
			end else if (adv_s1) begin
				vld_s1 <= 1'b0;
			end
			if (adv_s1) begin
				out_valid_q <= vld_s1;
			end
		end
	end

	// the slot written at the accept edge is caught here, the read saw the old one
	always_ff @(posedge clk) begin
		if (in_accept) begin
			req_s1  <= in_req;
			addr_s1 <= in_addr;
			lvl_s1  <= s_tdata[bmcd_pkg::ID_W];
			inr_s1  <= in_range;
			hit_s1  <= wr_en && (addr_s1 == in_addr);
			fwd_s1  <= nxt;
		end
		if (adv_s1 && vld_s1) begin
			out_data_q <= res;
		end
	end

	always_comb begin
		if (hit_s1) begin
			cur = fwd_s1;
		end else if (rd_valid) begin
			cur = slot_t'(rd_data);
		end else begin
			cur = '0;
		end
	end

	assign press_inc = (&cur.press_ticks) ? cur.press_ticks : cur.press_ticks + 1'b1;
	assign rel_inc   = (&cur.release_ticks) ? cur.release_ticks : cur.release_ticks + 1'b1;

	always_comb begin
		nxt       = cur;
		rep_valid = 1'b0;
		rep_count = '0;
		cap_out   = '0;
		case (req_s1)
			bmcd_pkg::REQ_SCAN: begin
				if (lvl_s1) begin
					nxt.press_ticks = press_inc;
					if (CW'(press_inc) < CW'(cfg.long_press)) begin
						nxt.event_state = (CW'(cur.release_ticks) < CW'(cfg.repress_window))
							? bmcd_pkg::EV_REPRESSED : bmcd_pkg::EV_PRESSED;
						nxt.release_ticks = '0;
					end else if (cur.event_state != bmcd_pkg::EV_LONG) begin
						nxt.event_state = bmcd_pkg::EV_LONG;
						nxt.captured    = bmcd_pkg::LONG_REPORT;
						nxt.clicks      = '0;
						rep_valid       = 1'b1;
						rep_count       = bmcd_pkg::LONG_REPORT;
					end
				end else begin
					nxt.release_ticks = rel_inc;
					if (CW'(cur.press_ticks) > CW'(cfg.debounce)) begin
						nxt.press_ticks = '0;
						case (cur.event_state)
							bmcd_pkg::EV_REPRESSED: begin
								if (cur.clicks < bmcd_pkg::CLICK_MAX) begin
									nxt.clicks = cur.clicks + 1'b1;
								end else begin
									nxt.clicks = bmcd_pkg::CLICK_MAX;
								end
							end
							bmcd_pkg::EV_PRESSED: nxt.clicks = bmcd_pkg::CNT_W'(1);
							bmcd_pkg::EV_LONG:    nxt.event_state = bmcd_pkg::EV_IDLE;
							default: begin
							end
						endcase
					end
					if ((CW'(rel_inc) > CW'(cfg.click_window))
						&& (nxt.event_state != bmcd_pkg::EV_IDLE)) begin
						rep_valid       = 1'b1;
						rep_count       = nxt.clicks;
						nxt.captured    = nxt.clicks;
						nxt.clicks      = '0;
						nxt.event_state = bmcd_pkg::EV_IDLE;
					end
				end
			end
			bmcd_pkg::REQ_READ: begin
				if ((cur.event_state == bmcd_pkg::EV_IDLE)
					|| (cur.event_state == bmcd_pkg::EV_LONG)) begin
					cap_out      = cur.captured;
					nxt.captured = '0;
				end
			end
			bmcd_pkg::REQ_CLEAR: begin
				nxt.clicks   = '0;
				nxt.captured = '0;
			end
			default: begin
			end
		endcase
	end

	// out-of-range buttons give an all-zero result
	assign res = inr_s1 ? {cap_out, rep_count, rep_valid, nxt.event_state} : '0;

	assign m_tvalid = out_valid_q;
	assign m_tdata  = bmcd_pkg::M_TDATA_W'(out_data_q);

	// a report only ever leaves the slot idle or long-pressed
	a_report_event: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tdata[2]) |-> (m_tdata[1:0] == bmcd_pkg::EV_IDLE
			|| m_tdata[1:0] == bmcd_pkg::EV_LONG))
		else $error("report with slot still pressed");

	// click counts never reach the long-press code
	a_click_count: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tdata[2] && m_tdata[1:0] == bmcd_pkg::EV_IDLE)
			|-> (m_tdata[10:3] != bmcd_pkg::LONG_REPORT))
		else $error("click report carries long-press count");

	// a read result and a report never share one result
	a_read_no_report: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tdata[18:11] != '0) |-> (!m_tdata[2] && m_tdata[10:3] == '0))
		else $error("captured count with report");

	// a stalled transaction keeps its slot
	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(vld_s1 && !adv_s1) |=> (vld_s1 && $stable(addr_s1) && $stable(req_s1)))
		else $error("stage 1 lost while stalled");

	// no write while the stage holds nothing
	a_write_valid: assert property (@(posedge clk) disable iff (!arst_n)
		wr_en |-> (vld_s1 && inr_s1))
		else $error("slot write without transaction");

endmodule

`default_nettype wire
